// ===== src/phtc_pkg.sv =====
package phtc_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int KEY_W       = 16;
    localparam int TS_W        = 5;
    localparam int OUT_SLOT_W  = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic [TS_W-1:0] TS_RESET = 5'd16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'd0,
        SEL_HOME = 2'd1,
        SEL_CUR  = 2'd2
    } slot_sel_t;

    typedef struct packed {
        logic      clr_step;
        logic      accept;
        logic      mod_start;
        logic      mod_occ;
        logic      home_load;
        logic      rd_en;
        logic      rd_tail;
        logic      key_wr_home;
        logic      key_wr_cur;
        logic      occ_load;
        logic      probe_step;
        logic      tail_init;
        logic      tail_step;
        logic      chain_step;
        logic      link_wr;
        logic      res_load;
        status_t   res_code;
        slot_sel_t res_sel;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_search;
        logic in_key_zero;
        logic op_search;
        logic mod_done;
        logic q_zero;
        logic q_match;
        logic probe_end;
        logic home_match;
        logic has_next;
        logic cnt_max;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== src/phtc_mod.sv =====
module phtc_mod
    import phtc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] dividend,
    input  logic [TS_W-1:0]  divisor,
    output logic             done,
    output logic [TS_W-1:0]  rem
);

    localparam int BIT_W = $clog2(KEY_W);

    logic [KEY_W-1:0] div_reg;
    logic [TS_W-1:0]  rem_reg;
    logic [BIT_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [TS_W:0]    trial;
    logic [TS_W:0]    divisor_ext;

    assign trial       = {rem_reg, div_reg[KEY_W-1]};
    assign divisor_ext = {1'b0, divisor};

    // restoring remainder, one dividend bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= '0;
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(KEY_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            div_reg <= {div_reg[KEY_W-2:0], 1'b0};
            if (trial >= divisor_ext)
                rem_reg <= TS_W'(trial - divisor_ext);
            else
                rem_reg <= trial[TS_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < divisor)
        else $error("remainder not below divisor");

endmodule

// ===== src/phtc_dp.sv =====
module phtc_dp
    import phtc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [TS_W-1:0]       cfg_wdata,
    input  logic                  in_op,
    input  logic [KEY_W-1:0]      in_key,
    input  logic                  out_ready,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic                  out_valid,
    output status_t               out_status,
    output logic [OUT_SLOT_W-1:0] out_slot
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > TS_W) ? CNT_W : TS_W;
    localparam int LINK_W = SLOT_W + 1;

    logic [TS_W-1:0]   ts_reg;
    logic [TS_W-1:0]   n;
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  occ_reg;
    logic [SLOT_W-1:0] home_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic [SLOT_W-1:0] tail_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0] clr_reg;
    status_t           res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [SLOT_W-1:0] res_slot_next;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [OUT_SLOT_W-1:0] out_slot_reg;

    logic [KEY_W-1:0]  key_mem [SLOTS];
    logic [LINK_W-1:0] link_mem [SLOTS];
    logic [KEY_W-1:0]  key_q;
    logic [LINK_W-1:0] link_q;
    logic [SLOT_W-1:0] link_idx;

    logic              key_we;
    logic [SLOT_W-1:0] key_wa;
    logic [KEY_W-1:0]  key_wd;
    logic              link_we;
    logic [SLOT_W-1:0] link_wa;
    logic [LINK_W-1:0] link_wd;
    logic [SLOT_W-1:0] rd_addr;

    logic [CMP_W-1:0]  cur_inc;
    logic [SLOT_W-1:0] cur_next;

    logic              mod_done;
    logic [TS_W-1:0]   mod_rem;
    logic [KEY_W-1:0]  mod_dividend;

    // effective table size, clamped to 2..SLOTS
    always_comb
    begin
        if (ts_reg < TS_W'(2))
            n = TS_W'(2);
        else if (int'(ts_reg) > SLOTS)
            n = TS_W'(SLOTS);
        else
            n = ts_reg;
    end

    assign mod_dividend = cmd.mod_occ ? occ_reg : in_key;

    phtc_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (mod_dividend),
        .divisor  (n),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign cur_inc  = CMP_W'(cur_reg) + CMP_W'(1);
    assign cur_next = (cur_inc == CMP_W'(n)) ? '0 : SLOT_W'(cur_inc);
    assign link_idx = link_q[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg        <= TS_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ts_reg <= cfg_wdata;
            if (cmd.clr_step)
                clr_reg <= clr_reg + SLOT_W'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        unique case (cmd.res_sel)
            SEL_ZERO: res_slot_next = '0;
            SEL_HOME: res_slot_next = home_reg;
            SEL_CUR:  res_slot_next = cur_reg;
            default:  res_slot_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_op;
            key_reg <= in_key;
        end
        if (cmd.occ_load)
            occ_reg <= key_q;
        if (cmd.home_load)
        begin
            home_reg <= SLOT_W'(mod_rem);
            cur_reg  <= SLOT_W'(mod_rem);
            cnt_reg  <= '0;
        end
        else if (cmd.probe_step)
        begin
            cur_reg <= cur_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.chain_step)
        begin
            cur_reg <= link_idx;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.tail_init)
        begin
            tail_reg <= home_reg;
            cnt_reg  <= '0;
        end
        else if (cmd.tail_step)
        begin
            tail_reg <= link_idx;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_code;
            res_slot_reg   <= res_slot_next;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= OUT_SLOT_W'(res_slot_reg);
        end
    end

    // single write port per store; the clearing pass shares it
    always_comb
    begin
        key_we  = cmd.clr_step || cmd.key_wr_home || cmd.key_wr_cur;
        key_wa  = cmd.clr_step ? clr_reg : (cmd.key_wr_home ? home_reg : cur_reg);
        key_wd  = cmd.clr_step ? '0 : key_reg;
        link_we = cmd.clr_step || cmd.link_wr;
        link_wa = cmd.clr_step ? clr_reg : tail_reg;
        link_wd = cmd.clr_step ? '0 : {1'b1, cur_reg};
        rd_addr = cmd.rd_tail ? tail_reg : cur_reg;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_wa] <= key_wd;
        if (link_we)
            link_mem[link_wa] <= link_wd;
        if (cmd.rd_en)
        begin
            key_q  <= key_mem[rd_addr];
            link_q <= link_mem[rd_addr];
        end
    end

    always_comb
    begin
        stat.clr_last    = clr_reg == SLOT_W'(SLOTS - 1);
        stat.in_search   = in_op == OP_SEARCH;
        stat.in_key_zero = in_key == '0;
        stat.op_search   = op_reg == OP_SEARCH;
        stat.mod_done    = mod_done;
        stat.q_zero      = key_q == '0;
        stat.q_match     = key_q == key_reg;
        stat.probe_end   = CMP_W'(cnt_reg) == CMP_W'(n);
        stat.home_match  = CMP_W'(mod_rem) == CMP_W'(home_reg);
        stat.has_next    = link_q[SLOT_W] && (CMP_W'(link_idx) < CMP_W'(n));
        stat.cnt_max     = cnt_reg == CNT_W'(SLOTS);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

    a_write_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.key_wr_cur |-> key_q == '0)
        else $error("probe wrote over an occupied slot");

    a_home_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.home_load) |-> CMP_W'(home_reg) < CMP_W'(n))
        else $error("home slot outside active table");

endmodule

// ===== src/phtc_ctrl.sv =====
module phtc_ctrl
    import phtc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     in_ready
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_HOME   = 12'b0000_0000_0100,
        S_RD     = 12'b0000_0000_1000,
        S_HCHK   = 12'b0000_0001_0000,
        S_PRD    = 12'b0000_0010_0000,
        S_PCHK   = 12'b0000_0100_0000,
        S_OMOD   = 12'b0000_1000_0000,
        S_TRD    = 12'b0001_0000_0000,
        S_TCHK   = 12'b0010_0000_0000,
        S_SCHK   = 12'b0100_0000_0000,
        S_RESULT = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.in_key_zero)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = stat.in_search ? ST_NOT_FOUND : ST_FULL;
                        cmd.res_sel  = SEL_ZERO;
                        state_next   = S_RESULT;
                    end
                    else
                    begin
                        cmd.mod_start = 1'b1;
                        state_next    = S_HOME;
                    end
                end
            end
            S_HOME:
            begin
                if (stat.mod_done)
                begin
                    cmd.home_load = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = stat.op_search ? S_SCHK : S_HCHK;
            end
            S_HCHK:
            begin
                if (stat.q_zero)
                begin
                    cmd.key_wr_home = 1'b1;
                    cmd.res_load    = 1'b1;
                    cmd.res_code    = ST_STORED;
                    cmd.res_sel     = SEL_HOME;
                    state_next      = S_RESULT;
                end
                else
                begin
                    cmd.occ_load   = 1'b1;
                    cmd.probe_step = 1'b1;
                    state_next     = S_PRD;
                end
            end
            S_PRD:
            begin
                if (stat.probe_end)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_FULL;
                    cmd.res_sel  = SEL_ZERO;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (stat.q_zero)
                begin
                    cmd.key_wr_cur = 1'b1;
                    cmd.mod_start  = 1'b1;
                    cmd.mod_occ    = 1'b1;
                    state_next     = S_OMOD;
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                    state_next     = S_PRD;
                end
            end
            S_OMOD:
            begin
                if (stat.mod_done)
                begin
                    if (stat.home_match)
                    begin
                        cmd.tail_init = 1'b1;
                        state_next    = S_TRD;
                    end
                    else
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ST_STORED;
                        cmd.res_sel  = SEL_CUR;
                        state_next   = S_RESULT;
                    end
                end
            end
            S_TRD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_tail = 1'b1;
                state_next  = S_TCHK;
            end
            S_TCHK:
            begin
                if (stat.has_next && !stat.cnt_max)
                begin
                    cmd.tail_step = 1'b1;
                    state_next    = S_TRD;
                end
                else
                begin
                    cmd.link_wr  = 1'b1;
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_STORED;
                    cmd.res_sel  = SEL_CUR;
                    state_next   = S_RESULT;
                end
            end
            S_SCHK:
            begin
                if (stat.q_match)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_FOUND;
                    cmd.res_sel  = SEL_CUR;
                    state_next   = S_RESULT;
                end
                else if (!stat.has_next || stat.cnt_max)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = ST_NOT_FOUND;
                    cmd.res_sel  = SEL_ZERO;
                    state_next   = S_RESULT;
                end
                else
                begin
                    cmd.chain_step = 1'b1;
                    state_next     = S_RD;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_mod_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        stat.mod_done |-> (state_reg == S_HOME || state_reg == S_OMOD))
        else $error("hash result arrived with no lookup waiting");

endmodule

// ===== src/probing_hash_table_with_chains_core.sv =====
// Hash table of nonzero 16-bit keys, linear probing plus per-home chains.
// An insert (tuser 0) or search (tuser 1) takes one item and gives one
// result. The hash key mod table_size runs on a bit-serial remainder
// unit. Each memory access goes through the single registered read
// port. Search reads the home slot, then walks its chain. Insert
// stores at home when it is empty; otherwise it probes for a free slot,
// hashes the home occupant and, if it belongs to that home, links the
// new slot at the chain's tail. Results leave through an output
// register. After reset the block clears both stores before taking
// items; configuration writes are taken at any time.
module probing_hash_table_with_chains_core
    import phtc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] key
    input  logic [0:0]             s_axis_tuser,   // [0] op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] slot_index, [7:4] zero
    output logic [1:0]             m_axis_tuser,   // [1:0] status
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [TS_W-1:0]        cfg_data        // table_size
);

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    status_t               out_status;
    logic [OUT_SLOT_W-1:0] out_slot;

    assign cfg_ready = 1'b1;

    phtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    phtc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_wdata  (cfg_data),
        .in_op      (s_axis_tuser[0]),
        .in_key     (s_axis_tdata[KEY_W-1:0]),
        .out_ready  (m_axis_tready),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_status (out_status),
        .out_slot   (out_slot)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_slot);
    assign m_axis_tuser = out_status;

endmodule
